### sv/mgops_pkg.sv
// shared types, constants and helpers for the multi-gate open pulse sequencer
// used by mgops_step and multi_gate_open_pulse_sequencer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mgops_pkg;

	localparam int NUM_GATES   = 2;
	localparam int STATUS_GATE = 1;
	localparam int SLOT_COUNT  = 2 * NUM_GATES;
	localparam int SLOT_W      = $clog2(SLOT_COUNT);

	localparam int TIME_W = 32;
	localparam int GATE_W = 3;
	localparam int PIN_W  = 8;

	localparam logic [TIME_W-1:0] PULSE_DURATION_RESET = TIME_W'(500);
	localparam logic              OPEN_LEVEL_RESET     = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_DURATION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_LEVEL     = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [TIME_W-1:0] now_time;
		logic [GATE_W-1:0] gate;
		logic [TIME_W-1:0] delay;
	} step_in_t;

	typedef struct packed {
		logic [NUM_GATES-1:0][TIME_W-1:0] close_time;
		logic [TIME_W-1:0]                slot_change_time;
		logic [SLOT_W-1:0]                slot_index;
	} seq_state_t;

	typedef struct packed {
		logic              indicator;
		logic [PIN_W-1:0]  gate_pins;
		logic [TIME_W-1:0] time_left;
	} step_res_t;

	typedef struct packed {
		logic [TIME_W-1:0] pulse_duration;
		logic              open_level;
	} seq_cfg_t;

	// wrap-safe "a is later than b"
	function automatic logic is_after(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[TIME_W-1];
	endfunction

endpackage

`default_nettype wire

### sv/multi_gate_open_pulse_sequencer.sv
// One control pass per input transfer gives exactly one result transfer. An item is
// registered on acceptance, evaluated against the gate deadlines and slot state once
// the result register is free or being read, and its result registered. A new item is
// taken every cycle unless the input is back-pressured, as mgops_step is combinational.
// Output stall holds the result register and, once the input register is also full,
// back-pressures the input. Configuration writes are always ready.
// top level; depends on mgops_pkg and mgops_step
`timescale 1ns / 1ps
`default_nettype none

module multi_gate_open_pulse_sequencer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               cmd,
	input  wire logic [mgops_pkg::TIME_W-1:0]       now_time,
	input  wire logic [mgops_pkg::GATE_W-1:0]       gate,
	input  wire logic [mgops_pkg::TIME_W-1:0]       delay,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    indicator,
	output logic [mgops_pkg::PIN_W-1:0]             gate_pins,
	output logic [mgops_pkg::TIME_W-1:0]            time_left,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [mgops_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mgops_pkg::TIME_W-1:0]       cfg_data
);
	import mgops_pkg::*;

	logic       valid_s1;
	step_in_t   item_s1;
	logic       valid_s2;
	step_res_t  res_s2;
	seq_state_t state_q;
	seq_cfg_t   cfg_q;
	seq_state_t state_nxt;
	step_res_t  res_nxt;
	logic       in_xfer;
	logic       advance;

	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	mgops_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= '{cmd: cmd, now_time: now_time, gate: gate, delay: delay};
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	// sequencer state moves only when an item passes the evaluation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_duration <= PULSE_DURATION_RESET;
			cfg_q.open_level     <= OPEN_LEVEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PULSE_DURATION: cfg_q.pulse_duration <= cfg_data;
				REG_OPEN_LEVEL:     cfg_q.open_level     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_valid = valid_s2;
	assign indicator = res_s2.indicator;
	assign gate_pins = res_s2.gate_pins;
	assign time_left = res_s2.time_left;

endmodule

`default_nettype wire

### sv/mgops_step.sv
// one control pass: applies a request, retires expired gates, steps the slot
// index and forms the pin levels; depends on mgops_pkg
`timescale 1ns / 1ps
`default_nettype none

module mgops_step (
	input  mgops_pkg::step_in_t   item,
	input  mgops_pkg::seq_state_t cur,
	input  mgops_pkg::seq_cfg_t   cfg,
	output mgops_pkg::seq_state_t nxt,
	output mgops_pkg::step_res_t  res
);
	import mgops_pkg::*;

	logic [TIME_W-1:0]    now_p1;
	logic [TIME_W-1:0]    cand;
	logic [NUM_GATES-1:0] hit;
	logic [NUM_GATES-1:0] active;
	logic [NUM_GATES-1:0] driven;
	logic [NUM_GATES-1:0][TIME_W-1:0] ct;
	logic [TIME_W-1:0]    sct;
	logic [SLOT_W-1:0]    slot;
	logic [PIN_W-1:0]     pins;

	assign now_p1 = item.now_time + TIME_W'(1);
	assign cand   = item.now_time + item.delay;

	always_comb begin
		for (int i = 0; i < NUM_GATES; i++) begin
			hit[i] = item.cmd && (item.gate == GATE_W'(i));
			ct[i]  = cur.close_time[i];
			if (hit[i]) begin
				if (item.delay[TIME_W-1]) begin
					ct[i] = item.now_time - TIME_W'(1);
				end else if (is_after(cand, cur.close_time[i])) begin
					ct[i] = cand;
				end
			end
			// expired gates snap to now
			active[i] = !is_after(item.now_time, ct[i]);
			if (!active[i]) begin
				ct[i] = item.now_time;
			end
		end

		sct  = ((|hit) && item.delay[TIME_W-1]) ? now_p1 : cur.slot_change_time;
		slot = cur.slot_index;
		if (active == '0) begin
			slot = '0;
			sct  = now_p1;
		end
		if (is_after(item.now_time, sct)) begin
			sct  = item.now_time + cfg.pulse_duration;
			slot = (slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot + SLOT_W'(1);
		end

		pins = '0;
		for (int i = 0; i < NUM_GATES; i++) begin
			driven[i] = active[i] && (slot == SLOT_W'(2 * i + 1));
			pins[i]   = cfg.open_level ? driven[i] : !driven[i];
		end
	end

	assign nxt.close_time       = ct;
	assign nxt.slot_change_time = sct;
	assign nxt.slot_index       = slot;

	assign res.indicator = |driven;
	assign res.gate_pins = pins;
	assign res.time_left = (STATUS_GATE < NUM_GATES)
		? item.now_time - ct[STATUS_GATE % NUM_GATES] : '0;

endmodule

`default_nettype wire

### verif/mgops_checker.sv
`timescale 1ns / 1ps
// checker for the multi-gate open pulse sequencer: watches the input, result and register
// channels, predicts every control pass and compares results in order; depends on mgops_pkg

module mgops_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic                            cmd,
	input  wire logic [mgops_pkg::TIME_W-1:0]    now_time,
	input  wire logic [mgops_pkg::GATE_W-1:0]    gate,
	input  wire logic [mgops_pkg::TIME_W-1:0]    delay,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic                            indicator,
	input  wire logic [mgops_pkg::PIN_W-1:0]     gate_pins,
	input  wire logic [mgops_pkg::TIME_W-1:0]    time_left,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [mgops_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mgops_pkg::TIME_W-1:0]    cfg_data,
	output int unsigned                          fail_count,
	output int unsigned                          awaiting
);
	import mgops_pkg::*;

	localparam int GIDX_W = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;

	// predicted sequencer state and register copies
	logic [TIME_W-1:0] deadline [NUM_GATES];
	logic [TIME_W-1:0] slot_due;
	int                slot_ptr;
	logic [TIME_W-1:0] cfg_pulse;
	logic              cfg_level;

	step_res_t   due_results [$];
	step_res_t   predicted;
	step_res_t   want;
	int unsigned bad;

	function automatic logic later_than(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] diff;
		diff = a - b;
		return (diff != '0) && (diff[TIME_W-1] == 1'b0);
	endfunction

	task automatic evaluate_pass(input logic c, input logic [TIME_W-1:0] now,
			input logic [GATE_W-1:0] g, input logic [TIME_W-1:0] d, output step_res_t r);
		logic [TIME_W-1:0]    cand;
		logic [NUM_GATES-1:0] live;
		logic                 hit;
		live = '0;
		if (c && g < NUM_GATES) begin
			if (d[TIME_W-1]) begin
				// cancel closes the window at once and forces a slot change
				deadline[GIDX_W'(g)] = now - 1;
				slot_due = now + 1;
			end else begin
				cand = now + d;
				if (later_than(cand, deadline[GIDX_W'(g)]))
					deadline[GIDX_W'(g)] = cand;
			end
		end
		for (int i = 0; i < NUM_GATES; i++) begin
			if (later_than(now, deadline[i]))
				deadline[i] = now;
			else
				live[i] = 1'b1;
		end
		if (live == '0) begin
			slot_ptr = 0;
			slot_due = now + 1;
		end
		if (later_than(now, slot_due)) begin
			slot_due = now + cfg_pulse;
			slot_ptr = (slot_ptr + 1) % SLOT_COUNT;
		end
		// odd slots drive gate slot/2, even slots are gaps
		hit = slot_ptr[0] && live[slot_ptr >> 1];
		r.indicator = hit;
		r.gate_pins = '0;
		for (int i = 0; i < NUM_GATES; i++)
			r.gate_pins[i] = (hit && (slot_ptr >> 1) == i) ? cfg_level : ~cfg_level;
		if (STATUS_GATE < NUM_GATES)
			r.time_left = now - deadline[STATUS_GATE % NUM_GATES];
		else
			r.time_left = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_GATES; i++)
				deadline[i] = '0;
			slot_due = '0;
			slot_ptr = 0;
			cfg_pulse = PULSE_DURATION_RESET;
			cfg_level = OPEN_LEVEL_RESET;
			due_results.delete();
			bad = 0;
			fail_count <= 0;
			awaiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PULSE_DURATION: cfg_pulse = cfg_data;
					REG_OPEN_LEVEL:     cfg_level = cfg_data[0];
				endcase
			end
			// retire before predicting so a stray result never meets a fresh entry
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					if (bad < 10)
						$display("unexpected result transfer: ind=%0b pins=%02h left=%08h",
							indicator, gate_pins, time_left);
					bad++;
				end else begin
					want = due_results.pop_front();
					if (indicator !== want.indicator || gate_pins !== want.gate_pins ||
							time_left !== want.time_left) begin
						if (bad < 10)
							$display("result mismatch: expected %0b %02h %08h, got %0b %02h %08h",
								want.indicator, want.gate_pins, want.time_left,
								indicator, gate_pins, time_left);
						bad++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				evaluate_pass(cmd, now_time, gate, delay, predicted);
				due_results.push_back(predicted);
			end
			fail_count <= bad;
			awaiting <= due_results.size();
		end
	end

endmodule

### verif/tb_multi_gate_open_pulse_sequencer.sv
`timescale 1ns / 1ps
// top of the sequencer testbench: clock, reset, register writes, directed and random
// control passes with random idling on both sides; depends on mgops_pkg and mgops_checker

module tb_multi_gate_open_pulse_sequencer;
	import mgops_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 240;
	localparam int HOLD_CYCLES = 80;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 cmd       = 1'b0;
	logic [TIME_W-1:0]    now_time  = '0;
	logic [GATE_W-1:0]    gate      = '0;
	logic [TIME_W-1:0]    delay     = '0;
	logic                 out_stall = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PULSE_DURATION;
	logic [TIME_W-1:0]    cfg_data  = '0;

	wire logic              in_stall;
	wire logic              out_valid;
	wire logic              indicator;
	wire logic [PIN_W-1:0]  gate_pins;
	wire logic [TIME_W-1:0] time_left;
	wire logic              cfg_ready;

	int unsigned fail_count;
	int unsigned awaiting;
	int unsigned cycle_count = 0;

	// stimulus shaping: quiet steers both sides, hold_req the receiver, tick and cur_pulse the sender
	bit                quiet    = 1'b0;
	bit                hold_req = 1'b0;
	logic [TIME_W-1:0] tick;
	logic [TIME_W-1:0] cur_pulse;

	logic [TIME_W-1:0] phase_pulse [6] = '{32'd0, 32'd1, 32'd7, 32'hFFFF_FFFF, 32'd37, 32'd500};
	logic              phase_level [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	multi_gate_open_pulse_sequencer uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .now_time(now_time), .gate(gate), .delay(delay),
		.out_valid(out_valid), .out_stall(out_stall),
		.indicator(indicator), .gate_pins(gate_pins), .time_left(time_left),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mgops_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .now_time(now_time), .gate(gate), .delay(delay),
		.out_valid(out_valid), .out_stall(out_stall),
		.indicator(indicator), .gate_pins(gate_pins), .time_left(time_left),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .awaiting(awaiting)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// one control pass; returns at the edge of its transfer
	task automatic offer(input logic c, input logic [TIME_W-1:0] t,
			input logic [GATE_W-1:0] g, input logic [TIME_W-1:0] d);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		now_time <= t;
		gate     <= g;
		delay    <= d;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic random_pass();
		int                pick;
		int unsigned       span;
		logic              c;
		logic [GATE_W-1:0] g;
		logic [TIME_W-1:0] d;
		span = (cur_pulse < 16) ? 16 : ((cur_pulse > 1000) ? 1000 : cur_pulse);
		pick = $urandom_range(0, 99);
		if (pick < 3)
			tick = $urandom();  // jump anywhere, backwards too
		else if (pick < 15)
			tick = tick + $urandom_range(0, 2);
		else
			tick = tick + $urandom_range(0, span);
		c = ($urandom_range(0, 99) < 35);
		if ($urandom_range(0, 9) == 0)
			g = GATE_W'($urandom_range(NUM_GATES, 7));
		else
			g = GATE_W'($urandom_range(0, NUM_GATES - 1));
		pick = $urandom_range(0, 99);
		if (pick < 15)
			d = $urandom() | 32'h8000_0000;
		else if (pick < 20)
			d = 32'hFFFF_FFFF;
		else if (pick < 28)
			d = $urandom() & 32'h7FFF_FFFF;
		else
			d = $urandom_range(0, 3 * span);
		offer(c, tick, g, d);
	endtask

	// stop offering and wait until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_settings(input logic [TIME_W-1:0] pulse, input logic level);
		cfg_valid <= 1'b1;
		cfg_index <= REG_PULSE_DURATION;
		cfg_data  <= pulse;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_OPEN_LEVEL;
		cfg_data  <= {{(TIME_W-1){1'b0}}, level};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_pulse = pulse;
	endtask

	// result side: random stall per transfer, one long hold-off on request
	initial begin
		int k;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				k = HOLD_CYCLES;
			end else begin
				k = quiet ? 0 : $urandom_range(0, 8);
			end
			if (k > 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		cur_pulse = PULSE_DURATION_RESET;
		tick = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed passes under the reset settings
		offer(1'b0, 32'd0, 3'd0, 32'd0);
		offer(1'b1, 32'd10, 3'd0, 32'd100);
		offer(1'b1, 32'd20, 3'd1, 32'h7FFF_FFFF);
		offer(1'b0, 32'd600, 3'd0, 32'd0);
		offer(1'b0, 32'd1200, 3'd7, 32'hFFFF_FFFF);
		offer(1'b1, 32'd1300, 3'd1, 32'd5);            // shorter window, no extension
		offer(1'b1, 32'd1900, 3'd1, 32'd0);
		offer(1'b1, 32'd2000, 3'd7, 32'h8000_0000);    // gate out of range, cancel ignored
		offer(1'b1, 32'd2100, 3'd2, 32'd300);
		offer(1'b1, 32'd2200, 3'd0, 32'hFFFF_FFFF);    // cancel
		offer(1'b1, 32'd2300, 3'd1, 32'h8000_0000);
		offer(1'b0, 32'd2301, 3'd0, 32'd0);
		offer(1'b1, 32'hFFFF_FFF0, 3'd0, 32'h20);      // window across the wrap
		offer(1'b0, 32'hFFFF_FFFF, 3'd0, 32'd0);
		offer(1'b1, 32'd0, 3'd1, 32'd1000);
		offer(1'b0, 32'd5, 3'd0, 32'd0);
		offer(1'b0, 32'd520, 3'd0, 32'd0);
		offer(1'b0, 32'd1100, 3'd0, 32'd0);
		offer(1'b1, 32'h7FFF_FFFF, 3'd0, 32'h7FFF_FFFF);
		offer(1'b0, 32'hFFFF_FFFE, 3'd3, 32'h1234_5678);
		tick = 32'hFFFF_FFFE;
		drain();

		for (int p = 0; p < 6; p++) begin
			write_settings(phase_pulse[p], phase_level[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				quiet = (n >= 150 && n < 200);
				if (p == 2 && n == 100)
					hold_req = 1'b1;
				random_pass();
			end
			quiet = 1'b0;
			drain();
		end

		if (fail_count == 0 && awaiting == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
sv/mgops_pkg.sv
sv/mgops_step.sv
sv/multi_gate_open_pulse_sequencer.sv
verif/mgops_checker.sv
verif/tb_multi_gate_open_pulse_sequencer.sv
